// ===== rtl/int64dm_pkg.sv =====
// package: shared types and constants for the 64-bit signed/unsigned divider
package int64dm_pkg;

    // default operand width and fixed field width on the ports
    localparam int DATA_WIDTH = 64;
    localparam int FIELD_W    = 64;

    // division modes
    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_SIGNED   = 1'b1;

    // command beat
    typedef struct packed {
        logic               op;
        logic [FIELD_W-1:0] dividend;
        logic [FIELD_W-1:0] divisor;
    } t_div_cmd;

    // result beat
    typedef struct packed {
        logic [FIELD_W-1:0] quotient;
        logic [FIELD_W-1:0] remainder;
        logic               div_by_zero;
    } t_div_rsp;

    // control that travels with each beat down the cell row
    typedef struct packed {
        logic valid;
        logic q_neg;
        logic r_neg;
        logic dz;
    } t_ctl;

endpackage

// ===== rtl/int64_divide_modulo_core.sv =====
// top level: pipelined signed/unsigned divider built as a row of divide cells
//
//  channel   ports                        direction  beat taken when
//  command   start, busy, i_cmd           in         start && !busy at clock edge
//  result    o_valid, o_rsp               out        o_valid high, one cycle only
//
// the row is one operand stage, one cell per quotient bit and one sign fix-up
// stage, all registered. a new command is taken every cycle; busy stays low.
// synchronous active-low reset clears every valid bit in the row; data
// registers are not reset. the receiver cannot stall, so nothing in the row ever waits.
module int64_divide_modulo_core #(
    parameter int DATA_WIDTH = int64dm_pkg::DATA_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  int64dm_pkg::t_div_cmd     i_cmd,
    output logic                      o_valid,
    output int64dm_pkg::t_div_rsp     o_rsp
);

    int64dm_pkg::t_ctl     w_ctl [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] w_rem [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] w_quo [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] w_dvs [0:DATA_WIDTH];

    // fully pipelined, never refuses a command
    assign busy = 1'b0;

    // operand stage
    int64dm_prep #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (start && !busy),
        .i_cmd   (i_cmd),
        .o_ctl   (w_ctl[0]),
        .o_quo   (w_quo[0]),
        .o_dvs   (w_dvs[0])
    );

    // partial remainder starts at zero
    assign w_rem[0] = '0;

    // row of divide cells, one quotient bit each
    for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_cell
        int64dm_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_rem   (w_rem[g]),
            .i_quo   (w_quo[g]),
            .i_dvs   (w_dvs[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_quo   (w_quo[g+1]),
            .o_dvs   (w_dvs[g+1])
        );
    end

    // sign fix-up and result register
    int64dm_post #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl[DATA_WIDTH]),
        .i_rem   (w_rem[DATA_WIDTH]),
        .i_quo   (w_quo[DATA_WIDTH]),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    // every command produces a result once it has passed through the whole row
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##(DATA_WIDTH + 2) o_valid)
        else $error("result missing after command");

    // no result without a valid beat from the last cell
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_ctl[DATA_WIDTH].valid))
        else $error("result beat without a beat from the last cell");

    // zero divisor gives an all-ones quotient
    a_dz_quotient: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.div_by_zero) |-> (o_rsp.quotient[DATA_WIDTH-1:0] == '1))
        else $error("zero divisor quotient not all ones");

    // final remainder is below the magnitude of the divisor unless the divisor is zero
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl[DATA_WIDTH].valid && !w_ctl[DATA_WIDTH].dz)
            |-> (w_rem[DATA_WIDTH] < w_dvs[DATA_WIDTH]))
        else $error("remainder not reduced below divisor");

endmodule

// ===== rtl/int64dm_prep.sv =====
// module: operand masking, zero-divisor detect and absolute values
module int64dm_prep #(
    parameter int DATA_WIDTH = int64dm_pkg::DATA_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_take,
    input  int64dm_pkg::t_div_cmd     i_cmd,
    output int64dm_pkg::t_ctl         o_ctl,
    output logic [DATA_WIDTH-1:0]     o_quo,
    output logic [DATA_WIDTH-1:0]     o_dvs
);

    logic [DATA_WIDTH-1:0] w_n;
    logic [DATA_WIDTH-1:0] w_d;
    logic                  w_dz;
    logic                  w_nneg;
    logic                  w_dneg;

    int64dm_pkg::t_ctl     r_ctl;
    int64dm_pkg::t_ctl     n_ctl;
    logic [DATA_WIDTH-1:0] r_quo;
    logic [DATA_WIDTH-1:0] n_quo;
    logic [DATA_WIDTH-1:0] r_dvs;
    logic [DATA_WIDTH-1:0] n_dvs;

    // signs and magnitudes; a zero divisor keeps the dividend unsigned
    always_comb begin
        w_n    = i_cmd.dividend[DATA_WIDTH-1:0];
        w_d    = i_cmd.divisor[DATA_WIDTH-1:0];
        w_dz   = (w_d == '0);
        w_nneg = (i_cmd.op == int64dm_pkg::OP_SIGNED) && w_n[DATA_WIDTH-1] && !w_dz;
        w_dneg = (i_cmd.op == int64dm_pkg::OP_SIGNED) && w_d[DATA_WIDTH-1];
        n_ctl.valid = i_take;
        n_ctl.q_neg = w_nneg ^ w_dneg;
        n_ctl.r_neg = w_nneg;
        n_ctl.dz    = w_dz;
        n_quo = w_nneg ? (~w_n + 1'b1) : w_n;
        n_dvs = w_dneg ? (~w_d + 1'b1) : w_d;
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    // operand registers
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_ctl = r_ctl;
    assign o_quo = r_quo;
    assign o_dvs = r_dvs;

endmodule

// ===== rtl/int64dm_cell.sv =====
// module: one restoring divide step, registered, one cell of the row
module int64dm_cell #(
    parameter int DATA_WIDTH = int64dm_pkg::DATA_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  int64dm_pkg::t_ctl         i_ctl,
    input  logic [DATA_WIDTH-1:0]     i_rem,
    input  logic [DATA_WIDTH-1:0]     i_quo,
    input  logic [DATA_WIDTH-1:0]     i_dvs,
    output int64dm_pkg::t_ctl         o_ctl,
    output logic [DATA_WIDTH-1:0]     o_rem,
    output logic [DATA_WIDTH-1:0]     o_quo,
    output logic [DATA_WIDTH-1:0]     o_dvs
);

    logic [DATA_WIDTH:0]   w_diff;
    logic                  w_fits;

    int64dm_pkg::t_ctl     r_ctl;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] n_rem;
    logic [DATA_WIDTH-1:0] r_quo;
    logic [DATA_WIDTH-1:0] n_quo;
    logic [DATA_WIDTH-1:0] r_dvs;

    // shift in next dividend bit, trial subtract, shift in quotient bit
    always_comb begin
        w_diff = {i_rem, i_quo[DATA_WIDTH-1]} - {1'b0, i_dvs};
        w_fits = !w_diff[DATA_WIDTH];
        n_rem  = w_fits ? w_diff[DATA_WIDTH-1:0]
                        : {i_rem[DATA_WIDTH-2:0], i_quo[DATA_WIDTH-1]};
        n_quo  = {i_quo[DATA_WIDTH-2:0], w_fits};
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // data registers
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= i_dvs;
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_quo = r_quo;
    assign o_dvs = r_dvs;

endmodule

// ===== rtl/int64dm_post.sv =====
// module: sign fix-up of quotient and remainder, result register
module int64dm_post #(
    parameter int DATA_WIDTH = int64dm_pkg::DATA_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  int64dm_pkg::t_ctl         i_ctl,
    input  logic [DATA_WIDTH-1:0]     i_rem,
    input  logic [DATA_WIDTH-1:0]     i_quo,
    output logic                      o_valid,
    output int64dm_pkg::t_div_rsp     o_rsp
);

    logic                  r_valid;
    int64dm_pkg::t_div_rsp r_rsp;
    int64dm_pkg::t_div_rsp n_rsp;

    // negate where signs demand, zero-extend to the port width
    always_comb begin
        n_rsp = '0;
        n_rsp.quotient[DATA_WIDTH-1:0]  = i_ctl.q_neg ? (~i_quo + 1'b1) : i_quo;
        n_rsp.remainder[DATA_WIDTH-1:0] = i_ctl.r_neg ? (~i_rem + 1'b1) : i_rem;
        n_rsp.div_by_zero               = i_ctl.dz;
    end

    // strobe register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule
